@@ hdl/priority_sound_effect_player_core_assert.svh @@
// Assertion macros for the sound-effect player core.
// Expects clk and rst_n in the scope of the including module.
`ifndef PRIORITY_SOUND_EFFECT_PLAYER_CORE_ASSERT_SVH
`define PRIORITY_SOUND_EFFECT_PLAYER_CORE_ASSERT_SVH

// same-cycle implication
`define PSEP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/psep_pkg.sv @@
// Shared types, constants and codes for the sound-effect player core.
// No dependencies; imported by the interfaces, the RAM users and the top level.
package psep_pkg;

    localparam int SAMPLE_DEPTH = 16384;   // power of two
    localparam int NUM_CHANNELS = 11;
    localparam int MARCH_SCALE  = 8;

    localparam int SAMPLE_AW = $clog2(SAMPLE_DEPTH);
    localparam int CH_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FUNC_W    = 3;
    localparam int CHAN_W    = 4;
    localparam int ADDR_W    = 14;
    localparam int DATA_W    = 8;
    localparam int LEN_W     = 15;
    localparam int RATE_W    = 16;
    localparam int IDX_W     = 14;
    localparam int VOL_W     = 16;
    localparam int MARCH_W   = 3;
    localparam int SMP_W     = 16;
    localparam int SUM_W     = (SAMPLE_AW > ADDR_W + 1) ? SAMPLE_AW : ADDR_W + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [SMP_W-1:0]   SILENCE_LEVEL  = SMP_W'(8 * 127);
    localparam logic [VOL_W-1:0]   VOL_STEP_RESET = VOL_W'(257);
    localparam logic [VOL_W-1:0]   VOL_MAX_RESET  = VOL_W'(7967);
    localparam logic [MARCH_W-1:0] MARCH_FIRST    = MARCH_W'(1);
    localparam logic [MARCH_W-1:0] MARCH_LAST     = MARCH_W'(4);

    localparam int CH_EXPLODE = 0;
    localparam int CH_FIRE    = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK        = 3'd0,
        FUNC_START       = 3'd1,
        FUNC_STOP        = 3'd2,
        FUNC_MARCH       = 3'd3,
        FUNC_VOL_UP      = 3'd4,
        FUNC_VOL_DOWN    = 3'd5,
        FUNC_WR_SAMPLE   = 3'd6,
        FUNC_WR_DESC     = 3'd7
    } func_t;

    typedef enum logic {
        REG_VOLUME_STEP = 1'b0,
        REG_VOLUME_MAX  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        func_t               func;
        logic [CHAN_W-1:0]   channel;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   data;
        logic [LEN_W-1:0]    length;
        logic [RATE_W-1:0]   rate;
    } psep_item_t;

    typedef struct packed {
        logic [2*SMP_W-1:0]  stereo_word;
        logic [CHAN_W-1:0]   playing_channel;
        logic [RATE_W-1:0]   rate_out;
        logic                rate_write;
        logic [VOL_W-1:0]    volume_level;
        logic                volume_write;
        logic [MARCH_W-1:0]  march_step;
    } psep_result_t;

    // per-word info carried from the issue stage to the sample-read stage
    typedef struct packed {
        logic                tick;
        logic                played;
        logic                is_march;
        logic [CHAN_W-1:0]   playing;
        logic                vol_write;
        logic [VOL_W-1:0]    volume;
        logic [MARCH_W-1:0]  march;
    } psep_meta_t;

endpackage

@@ hdl/psep_item_if.sv @@
// Input channel of the sound-effect player: valid/ready plus one item word.
// Depends on psep_pkg.
interface psep_item_if import psep_pkg::*; ();

    logic       valid;
    logic       ready;
    psep_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

@@ hdl/psep_result_if.sv @@
// Result channel of the sound-effect player: valid/ready plus one result word.
// Depends on psep_pkg.
interface psep_result_if import psep_pkg::*; ();

    logic         valid;
    logic         ready;
    psep_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

@@ hdl/psep_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds until the next enabled read. No dependencies.
module psep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/priority_sound_effect_player_core.sv @@
// Priority sound-effect player core. An item passes the sample-read stage register, then the
// output register. Throughput: one item per cycle unless both stages are full and result.ready
// is low. Sample and rate RAMs have a registered read into the second stage. Reset (rst_n,
// async, low) clears active flags, play indexes, pipeline valids and sets march step 1 and the
// attenuation to 7967; descriptors and sample memory are not cleared, no sweep needed.
// Depends on psep_pkg, psep_item_if, psep_result_if, psep_ram and the assert macros.
`include "priority_sound_effect_player_core_assert.svh"

module priority_sound_effect_player_core import psep_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    psep_item_if.sink           item,
    psep_result_if.source       result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // configuration
    logic [VOL_W-1:0] vol_step_reg;
    logic [VOL_W-1:0] vol_max_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    // channel state
    logic [NUM_CHANNELS-1:0] active_reg, active_next;
    logic [IDX_W-1:0]        index_reg [NUM_CHANNELS];
    logic [IDX_W-1:0]        index_next [NUM_CHANNELS];
    logic [ADDR_W-1:0]       base_reg [NUM_CHANNELS];
    logic [LEN_W-1:0]        length_reg [NUM_CHANNELS];
    logic [MARCH_W-1:0]      march_reg, march_next;
    logic [VOL_W-1:0]        atten_reg, atten_next;

    // issue stage
    logic              accept;
    psep_item_t        it;
    logic              ch_ok;
    logic [CH_AW-1:0]  ch_i;
    logic              any_active;
    logic [CH_AW-1:0]  sel;
    logic              sel_march;
    logic [SUM_W-1:0]  rd_sum;
    logic [SUM_W-1:0]  wr_sum;
    logic              tick_play;
    psep_meta_t        meta_next;

    // sample-read stage and output register
    logic              s1_valid_reg, s1_valid_next;
    psep_meta_t        s1_meta_reg;
    logic              s1_move;
    logic [DATA_W-1:0] sample_rdata;
    logic [RATE_W-1:0] rate_rdata;
    logic [SMP_W-1:0]  smp;
    logic              out_valid_reg, out_valid_next;
    psep_result_t      out_reg, out_next;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_VOLUME_STEP: prdata = PDATA_W'(vol_step_reg);
            REG_VOLUME_MAX:  prdata = PDATA_W'(vol_max_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_step_reg <= VOL_STEP_RESET;
            vol_max_reg  <= VOL_MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_VOLUME_STEP: vol_step_reg <= pwdata[VOL_W-1:0];
                REG_VOLUME_MAX:  vol_max_reg  <= pwdata[VOL_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- issue stage ----------------
    assign item.ready = !s1_valid_reg || !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign it         = item.payload;
    assign ch_ok      = {1'b0, it.channel} < (CHAN_W + 1)'(NUM_CHANNELS);
    assign ch_i       = it.channel[CH_AW-1:0];

    // highest-priority active channel: lowest number wins
    always_comb
    begin
        any_active = 1'b0;
        sel        = '0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--)
        begin
            if (active_reg[c])
            begin
                any_active = 1'b1;
                sel        = CH_AW'(c);
            end
        end
    end

    assign sel_march = int'(sel) >= NUM_CHANNELS - 4;
    assign tick_play = accept && (it.func == FUNC_TICK) && any_active;
    assign rd_sum    = SUM_W'(base_reg[sel]) + SUM_W'(index_reg[sel]);
    assign wr_sum    = SUM_W'(it.address);

    always_comb
    begin
        logic [IDX_W:0]     nxt;
        logic [VOL_W:0]     vsum;
        logic [MARCH_W-1:0] want;
        int                 k;

        active_next = active_reg;
        index_next  = index_reg;
        march_next  = march_reg;
        atten_next  = atten_reg;
        nxt         = '0;
        vsum        = '0;
        want        = MARCH_LAST;
        k           = 0;

        if (accept)
        begin
            case (it.func)
                FUNC_TICK:
                begin
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        nxt = {1'b0, index_reg[c]}
                            + (IDX_W + 1)'(any_active && (int'(sel) == c));
                        k = c - (NUM_CHANNELS - 5);
                        if (nxt >= length_reg[c])
                        begin
                            // sound done: go idle, rewind, and on a march channel advance march step
                            active_next[c] = 1'b0;
                            index_next[c]  = '0;
                            if (k >= 1 && k <= 4)
                            begin
                                march_next = (k == 4) ? MARCH_FIRST : MARCH_W'(k + 1);
                            end
                        end
                        else
                        begin
                            index_next[c] = nxt[IDX_W-1:0];
                        end
                    end
                end
                FUNC_START:
                begin
                    if (ch_ok)
                    begin
                        active_next[ch_i] = 1'b1;
                        // explode cuts off fire
                        for (int c = 0; c < NUM_CHANNELS; c++)
                        begin
                            if (c == CH_FIRE && CH_FIRE != CH_EXPLODE
                                && int'(ch_i) == CH_EXPLODE)
                            begin
                                active_next[c] = 1'b0;
                                index_next[c]  = '0;
                            end
                        end
                    end
                end
                FUNC_STOP:
                begin
                    if (ch_ok)
                    begin
                        active_next[ch_i] = 1'b0;
                        for (int c = 0; c < NUM_CHANNELS; c++)
                        begin
                            if (c == CH_FIRE && int'(ch_i) == CH_FIRE)
                            begin
                                index_next[c] = '0;
                            end
                        end
                    end
                end
                FUNC_MARCH:
                begin
                    want = (march_reg >= MARCH_FIRST && march_reg < MARCH_LAST)
                         ? march_reg : MARCH_LAST;
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        k = c - (NUM_CHANNELS - 5);
                        if (k >= 1 && k <= 4)
                        begin
                            active_next[c] = (MARCH_W'(k) == want);
                        end
                    end
                end
                FUNC_VOL_UP:
                begin
                    if (atten_reg <= vol_max_reg && atten_reg != '0)
                    begin
                        atten_next = (atten_reg > vol_step_reg)
                                   ? atten_reg - vol_step_reg : '0;
                    end
                end
                FUNC_VOL_DOWN:
                begin
                    if (atten_reg < vol_max_reg)
                    begin
                        vsum       = {1'b0, atten_reg} + {1'b0, vol_step_reg};
                        atten_next = (vsum > {1'b0, vol_max_reg})
                                   ? vol_max_reg : vsum[VOL_W-1:0];
                    end
                end
                default:
                begin
                    // sample and descriptor writes touch storage only
                end
            endcase
        end
    end

    always_comb
    begin
        meta_next.tick      = it.func == FUNC_TICK;
        meta_next.played    = (it.func == FUNC_TICK) && any_active;
        meta_next.is_march  = sel_march;
        meta_next.playing   = ((it.func == FUNC_TICK) && any_active)
                            ? CHAN_W'(sel) : CHAN_W'(NUM_CHANNELS);
        meta_next.vol_write = (it.func == FUNC_VOL_UP) || (it.func == FUNC_VOL_DOWN);
        meta_next.volume    = atten_next;
        meta_next.march     = march_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            march_reg  <= MARCH_FIRST;
            atten_reg  <= VOL_MAX_RESET;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                index_reg[c] <= '0;
            end
        end
        else
        begin
            active_reg <= active_next;
            march_reg  <= march_next;
            atten_reg  <= atten_next;
            index_reg  <= index_next;
        end
    end

    // descriptor base and length stay in flops: every tick checks all lengths
    always_ff @(posedge clk)
    begin
        if (accept && it.func == FUNC_WR_DESC && ch_ok)
        begin
            base_reg[ch_i]   <= it.address;
            length_reg[ch_i] <= it.length;
        end
    end

    psep_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (accept && it.func == FUNC_WR_SAMPLE),
        .waddr (wr_sum[SAMPLE_AW-1:0]),
        .wdata (it.data),
        .re    (tick_play),
        .raddr (rd_sum[SAMPLE_AW-1:0]),
        .rdata (sample_rdata)
    );

    psep_ram #(
        .WIDTH (RATE_W),
        .DEPTH (NUM_CHANNELS)
    ) u_rate_ram (
        .clk   (clk),
        .we    (accept && it.func == FUNC_WR_DESC && ch_ok),
        .waddr (ch_i),
        .wdata (it.rate),
        .re    (tick_play),
        .raddr (sel),
        .rdata (rate_rdata)
    );

    // ---------------- sample-read stage ----------------
    // RAM read data holds while this stage stalls: no new tick is accepted then
    assign s1_move = s1_valid_reg && (!out_valid_reg || result.ready);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_next;
        end
    end

    always_comb
    begin
        if (!s1_meta_reg.played)
        begin
            smp = SILENCE_LEVEL;
        end
        else if (s1_meta_reg.is_march)
        begin
            smp = SMP_W'({{(SMP_W - DATA_W){1'b0}}, sample_rdata} * SMP_W'(MARCH_SCALE));
        end
        else
        begin
            smp = SMP_W'(sample_rdata);
        end
    end

    always_comb
    begin
        out_next.stereo_word     = s1_meta_reg.tick ? {smp, smp} : '0;
        out_next.playing_channel = s1_meta_reg.playing;
        out_next.rate_out        = s1_meta_reg.played ? rate_rdata : '0;
        out_next.rate_write      = s1_meta_reg.played;
        out_next.volume_level    = s1_meta_reg.volume;
        out_next.volume_write    = s1_meta_reg.vol_write;
        out_next.march_step      = s1_meta_reg.march;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // ---------------- assertions ----------------
    `PSEP_ASSERT_NOW(a_march_range, 1'b1, march_reg != '0 && march_reg <= MARCH_LAST, "march step left 1..4")
    `PSEP_ASSERT_NOW(a_stall_full, !item.ready, s1_valid_reg && out_valid_reg, "input stalled with a free stage")
    `PSEP_ASSERT_NEXT(a_s1_hold, s1_valid_reg && out_valid_reg && !result.ready, s1_valid_reg, "word lost in read stage")

endmodule

@@ dv/psep_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the sound-effect player bench: its own copy of channel, sample and volume
// state, a predictor of the result word of each item, and the in-order result check.
// Depends on psep_pkg.
package psep_tb_pkg;
    import psep_pkg::*;

    class sfx_scoreboard;
        logic [VOL_W-1:0]   vol_step;
        logic [VOL_W-1:0]   vol_max;
        logic [VOL_W-1:0]   atten;
        logic [MARCH_W-1:0] march;
        bit                 active [NUM_CHANNELS];
        logic [IDX_W-1:0]   play_idx [NUM_CHANNELS];
        logic [ADDR_W-1:0]  snd_base [NUM_CHANNELS];
        logic [LEN_W-1:0]   snd_len [NUM_CHANNELS];
        logic [RATE_W-1:0]  snd_rate [NUM_CHANNELS];
        logic [DATA_W-1:0]  samples [SAMPLE_DEPTH];
        psep_result_t       expected_words [$];
        int                 mismatches;

        function new();
            vol_step = VOL_STEP_RESET;
            vol_max = VOL_MAX_RESET;
            atten = VOL_MAX_RESET;
            march = MARCH_FIRST;
            mismatches = 0;
            foreach (active[c])
            begin
                active[c] = 1'b0;
                play_idx[c] = '0;
            end
        endfunction

        function void write_reg(reg_idx_t r, logic [VOL_W-1:0] v);
            if (r == REG_VOLUME_STEP)
                vol_step = v;
            else
                vol_max = v;
        endfunction

        // Sample address the next tick reads, if any channel is active.
        function bit tick_reads(output logic [SAMPLE_AW-1:0] addr);
            int c;
            addr = '0;
            for (c = 0; c < NUM_CHANNELS; c++)
            begin
                if (active[c])
                begin
                    addr = SAMPLE_AW'(snd_base[c] + play_idx[c]);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function psep_result_t play_word(psep_item_t w);
            psep_result_t         r;
            int                   c;
            int                   k;
            int                   sel;
            int                   want;
            bit                   ch_ok;
            logic [LEN_W-1:0]     nxt [NUM_CHANNELS];
            logic [SAMPLE_AW-1:0] addr;
            logic [SMP_W-1:0]     smp;
            logic [VOL_W:0]       sum;
            r = '0;
            r.playing_channel = CHAN_W'(NUM_CHANNELS);
            ch_ok = (w.channel < NUM_CHANNELS);
            case (w.func)
                FUNC_TICK:
                begin
                    sel = -1;
                    smp = SILENCE_LEVEL;
                    for (c = 0; c < NUM_CHANNELS; c++)
                    begin
                        nxt[c] = LEN_W'(play_idx[c]);
                        if (sel < 0 && active[c])
                            sel = c;
                    end
                    if (sel >= 0)
                    begin
                        addr = SAMPLE_AW'(snd_base[sel] + play_idx[sel]);
                        smp = SMP_W'(samples[addr]);
                        k = sel - (NUM_CHANNELS - 5);
                        if (k >= 1 && k <= 4)
                            smp = smp * SMP_W'(MARCH_SCALE);
                        nxt[sel] = nxt[sel] + 1'b1;
                        r.playing_channel = CHAN_W'(sel);
                        r.rate_out = snd_rate[sel];
                        r.rate_write = 1'b1;
                    end
                    // every channel at or past its length drops out, playing or not
                    for (c = 0; c < NUM_CHANNELS; c++)
                    begin
                        if (nxt[c] >= snd_len[c])
                        begin
                            active[c] = 1'b0;
                            nxt[c] = '0;
                            k = c - (NUM_CHANNELS - 5);
                            if (k >= 1 && k <= 4)
                                march = (k == 4) ? MARCH_FIRST : MARCH_W'(k + 1);
                        end
                        play_idx[c] = nxt[c][IDX_W-1:0];
                    end
                    r.stereo_word = {smp, smp};
                end
                FUNC_START:
                begin
                    if (ch_ok)
                    begin
                        active[w.channel] = 1'b1;
                        if (w.channel == CH_EXPLODE)
                        begin
                            active[CH_FIRE] = 1'b0;
                            play_idx[CH_FIRE] = '0;
                        end
                    end
                end
                FUNC_STOP:
                begin
                    if (ch_ok)
                    begin
                        active[w.channel] = 1'b0;
                        if (w.channel == CH_FIRE)
                            play_idx[CH_FIRE] = '0;
                    end
                end
                FUNC_MARCH:
                begin
                    want = (march >= 1 && march <= 3) ? int'(march) : 4;
                    for (k = 1; k <= 4; k++)
                        active[NUM_CHANNELS - 5 + k] = (k == want);
                end
                FUNC_VOL_UP:
                begin
                    if (atten <= vol_max && atten > 0)
                        atten = (atten > vol_step) ? atten - vol_step : '0;
                    r.volume_write = 1'b1;
                end
                FUNC_VOL_DOWN:
                begin
                    if (atten < vol_max)
                    begin
                        sum = atten + vol_step;
                        atten = (sum > vol_max) ? vol_max : sum[VOL_W-1:0];
                    end
                    r.volume_write = 1'b1;
                end
                FUNC_WR_SAMPLE:
                    samples[w.address] = w.data;
                FUNC_WR_DESC:
                begin
                    if (ch_ok)
                    begin
                        snd_base[w.channel] = w.address;
                        snd_len[w.channel] = w.length;
                        snd_rate[w.channel] = w.rate;
                    end
                end
            endcase
            r.volume_level = atten;
            r.march_step = march;
            return r;
        endfunction

        function void note_item(psep_item_t w);
            expected_words.push_back(play_word(w));
        endfunction

        function void compare_field(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%s mismatch: expected 0x%0h, got 0x%0h", what, want, got);
            end
        endfunction

        function void check_result(psep_result_t got);
            psep_result_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word 0x%0h arrived with nothing expected", got);
                return;
            end
            want = expected_words.pop_front();
            compare_field("stereo_word", want.stereo_word, got.stereo_word);
            compare_field("playing_channel", want.playing_channel, got.playing_channel);
            compare_field("rate_out", want.rate_out, got.rate_out);
            compare_field("rate_write", want.rate_write, got.rate_write);
            compare_field("volume_level", want.volume_level, got.volume_level);
            compare_field("volume_write", want.volume_write, got.volume_write);
            compare_field("march_step", want.march_step, got.march_step);
        endfunction

        function bit failed();
            return (mismatches != 0) || (expected_words.size() != 0);
        endfunction
    endclass

endpackage

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Top-level bench for priority_sound_effect_player_core: directed and random item streams
// with bursty input, stalling output and volume register changes.
// Depends on psep_pkg, psep_item_if, psep_result_if and psep_tb_pkg.
module tb;
    import psep_pkg::*;
    import psep_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_AT    = 150;
    localparam int PRESSURE_HOLD  = 400;
    localparam int RANDOM_ITEMS   = 200;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    psep_item_if   item_ch ();
    psep_result_if result_ch ();

    priority_sound_effect_player_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sfx_scoreboard sb;
    bit            smp_written [SAMPLE_DEPTH];
    int            burst_left = 0;
    int            idle_gap = 0;
    bit            offering = 1'b0;
    int            results_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one word and hold it until accepted; at the end of a burst, maybe open an idle gap.
    task automatic drive_word(input psep_item_t w);
        if (idle_gap > 0)
        begin
            repeat (idle_gap) @(posedge clk);
            idle_gap = 0;
        end
        item_ch.payload <= w;
        item_ch.valid <= 1'b1;
        offering = 1'b1;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        sb.note_item(w);
        if (w.func == FUNC_WR_SAMPLE)
            smp_written[w.address] = 1'b1;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 30);
            idle_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (idle_gap > 0)
            begin
                item_ch.valid <= 1'b0;
                offering = 1'b0;
            end
        end
    endtask

    function automatic psep_item_t random_word();
        psep_item_t w;
        int         pick;
        w.channel = CHAN_W'($urandom);
        w.address = ADDR_W'($urandom);
        w.data = DATA_W'($urandom);
        w.length = LEN_W'($urandom);
        w.rate = RATE_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 44)
            w.func = FUNC_TICK;
        else if (pick < 56)
            w.func = FUNC_START;
        else if (pick < 64)
            w.func = FUNC_STOP;
        else if (pick < 70)
            w.func = FUNC_MARCH;
        else if (pick < 76)
            w.func = FUNC_VOL_UP;
        else if (pick < 82)
            w.func = FUNC_VOL_DOWN;
        else if (pick < 90)
            w.func = FUNC_WR_SAMPLE;
        else
            w.func = FUNC_WR_DESC;
        if (w.func inside {FUNC_START, FUNC_STOP, FUNC_WR_DESC})
        begin
            if ($urandom_range(0, 99) < 88)
                w.channel = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
            else
                w.channel = CHAN_W'($urandom_range(NUM_CHANNELS, 15));
        end
        // keep most sounds short so that channels keep finishing and handing over
        if (w.func == FUNC_WR_DESC && $urandom_range(0, 99) >= 4)
            w.length = LEN_W'($urandom_range(0, 24));
        return w;
    endfunction

    // A tick must not read a sample that was never written: write it first.
    task automatic issue(input psep_item_t w);
        psep_item_t           fill;
        logic [SAMPLE_AW-1:0] addr;
        bit                   reads;
        reads = 1'b0;
        if (w.func == FUNC_TICK)
            reads = sb.tick_reads(addr);
        if (reads && !smp_written[addr])
        begin
            fill = random_word();
            fill.func = FUNC_WR_SAMPLE;
            fill.address = addr;
            drive_word(fill);
        end
        drive_word(w);
    endtask

    task automatic send(input func_t f, input int unsigned ch, input int unsigned addr = 0,
                        input int unsigned data = 0, input int unsigned len = 0,
                        input int unsigned rate = 0);
        psep_item_t w;
        w.func = f;
        w.channel = CHAN_W'(ch);
        w.address = ADDR_W'(addr);
        w.data = DATA_W'(data);
        w.length = LEN_W'(len);
        w.rate = RATE_W'(rate);
        issue(w);
    endtask

    task automatic run_random(input int n);
        psep_item_t w;
        int         done;
        done = 0;
        while (done < n)
        begin
            w = random_word();
            issue(w);
            if (!(w.func inside {FUNC_START, FUNC_STOP, FUNC_WR_DESC}) ||
                w.channel < NUM_CHANNELS)
                done++;
        end
    endtask

    // Drop valid and wait until every expected word is back.
    task automatic settle();
        if (offering)
        begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input reg_idx_t r, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {r, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_volume_regs(input logic [VOL_W-1:0] step, input logic [VOL_W-1:0] vmax);
        logic [PDATA_W-1:0] rd;
        settle();
        apb_access(1'b1, REG_VOLUME_STEP, PDATA_W'(step), rd);
        sb.write_reg(REG_VOLUME_STEP, step);
        apb_access(1'b1, REG_VOLUME_MAX, PDATA_W'(vmax), rd);
        sb.write_reg(REG_VOLUME_MAX, vmax);
        apb_access(1'b0, REG_VOLUME_STEP, '0, rd);
        sb.compare_field("volume_step readback", PDATA_W'(step), rd);
        apb_access(1'b0, REG_VOLUME_MAX, '0, rd);
        sb.compare_field("volume_max_atten readback", PDATA_W'(vmax), rd);
    endtask

    task automatic run_directed();
        int c;
        // every channel needs a descriptor before the first tick checks lengths
        for (c = 0; c < NUM_CHANNELS; c++)
        begin
            if (c == CH_EXPLODE)
                send(FUNC_WR_DESC, c, 16'h3FFE, 0, 4, 16'hFFFF);   // wraps past top of memory
            else if (c == 1)
                send(FUNC_WR_DESC, c, 0, 0, 0, 0);                 // zero length
            else if (c >= NUM_CHANNELS - 4)
                send(FUNC_WR_DESC, c, 8000 + 4 * c, 0, 2, $urandom);
            else
                send(FUNC_WR_DESC, c, 400 * c, 0, 3 + c, $urandom);
        end
        send(FUNC_WR_DESC, 15, 16'h3FFF, 8'hFF, 16'h7FFF, 16'hFFFF);  // no such channel
        send(FUNC_TICK, 0);                                           // nothing active
        send(FUNC_START, CH_FIRE);
        send(FUNC_TICK, 0);
        send(FUNC_START, CH_EXPLODE);                                 // silences fire
        send(FUNC_TICK, 0);
        send(FUNC_STOP, CH_EXPLODE);
        send(FUNC_START, 1);
        send(FUNC_TICK, 0);
        send(FUNC_MARCH, 5);
        send(FUNC_TICK, 0);
        send(FUNC_TICK, 0);                                           // march step advances
        send(FUNC_START, 12);
        send(FUNC_VOL_DOWN, 0);
        send(FUNC_VOL_UP, 0);
        send(FUNC_WR_SAMPLE, 0, 16'h3FFF, 8'hFF);
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_ch.valid <= 1'b0;
        item_ch.payload <= '0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_ITEMS);
        set_volume_regs(16'hFFFF, 16'hFFFF);
        run_random(RANDOM_ITEMS);
        set_volume_regs(16'd3, 16'd40);
        run_random(RANDOM_ITEMS);
        set_volume_regs(16'd0, 16'd0);
        run_random(RANDOM_ITEMS);
        set_volume_regs(VOL_W'($urandom_range(1, 3000)), VOL_W'($urandom));
        run_random(RANDOM_ITEMS);
        settle();
        if (!sb.failed())
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : result_sink
        int run;
        int mode;
        int hold;
        bit pressed;
        run = 0;
        mode = 0;
        hold = 0;
        pressed = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if (!pressed && results_seen >= PRESSURE_AT)
            begin
                // hold off draining while items keep coming, so the input backs up
                pressed = 1'b1;
                hold = PRESSURE_HOLD;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (run == 0)
                begin
                    run = $urandom_range(20, 200);
                    mode = $urandom_range(0, 2);
                end
                run--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                    default: result_ch.ready <= (run % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            sb.check_result(result_ch.payload);
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                psel === 1'b1 || rst_n !== 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

@@ priority_sound_effect_player_core.f @@
+incdir+hdl
hdl/psep_pkg.sv
hdl/psep_item_if.sv
hdl/psep_result_if.sv
hdl/psep_ram.sv
hdl/priority_sound_effect_player_core.sv
dv/psep_tb_pkg.sv
dv/tb.sv
